[hdl/cts_pkg.sv]
package cts_pkg;

    // Item kind codes
    localparam logic [2:0] KIND_TICK       = 3'd0;
    localparam logic [2:0] KIND_DISPATCH   = 3'd1;
    localparam logic [2:0] KIND_COMPLETE   = 3'd2;
    localparam logic [2:0] KIND_MAKE_READY = 3'd3;
    localparam logic [2:0] KIND_SET_PERIOD = 3'd4;

    // Slot status codes
    localparam logic [1:0] ST_SLEEP    = 2'd0;
    localparam logic [1:0] ST_BLOCKED  = 2'd1;
    localparam logic [1:0] ST_RUNNABLE = 2'd2;
    localparam logic [1:0] ST_RUNNING  = 2'd3;

    // Width of the ready mask and of the visible runnable set
    localparam int MASK_BITS = 8;

    // Input item
    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  task_req;
        logic [7:0]  ready_mask;
        logic [15:0] period_value;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic [2:0] chosen_task;
        logic       fell_back;
        logic [7:0] runnable_set;
    } t_out_item;

    // Controller to datapath commands
    typedef struct packed {
        logic load_item;   // capture input item, clear walk index and fallback flag
        logic idx_inc;     // advance walk index
        logic rd_cur;      // read slot tables at current slot instead of walk index
        logic tick_wb;     // apply tick rules to the slot read last cycle
        logic disp_take;   // mark walk slot running and make it current
        logic cmpl_wb;     // finish a complete item on the slot read last cycle
        logic req_wr;      // make_ready or set_period write
        logic out_load;    // load the result register
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic [2:0] kind;
        logic       enable;
        logic       run_hit;   // slot at walk index is runnable
        logic       idx_last;  // walk index is the idle slot
        logic       wb_last;   // slot read last cycle is the idle slot
        logic       out_busy;  // result register full and not being taken
    } t_sts;

endpackage

[hdl/cts_ctrl.sv]
module cts_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  cts_pkg::t_sts i_sts,
    output cts_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_TICK0,
        S_TICK,
        S_DISP,
        S_CMPL,
        S_DONE
    } t_state;

    t_state r_state, n_state;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_sts.kind)
                    cts_pkg::KIND_TICK: begin
                        n_state = i_sts.enable ? S_TICK0 : S_DONE;
                    end
                    cts_pkg::KIND_DISPATCH: begin
                        n_state = S_DISP;
                    end
                    cts_pkg::KIND_COMPLETE: begin
                        o_cmd.rd_cur = 1'b1;
                        n_state      = S_CMPL;
                    end
                    cts_pkg::KIND_MAKE_READY, cts_pkg::KIND_SET_PERIOD: begin
                        o_cmd.req_wr = 1'b1;
                        n_state      = S_DONE;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            // first read of the tick walk
            S_TICK0: begin
                o_cmd.idx_inc = 1'b1;
                n_state       = S_TICK;
            end
            // write back one slot while reading the next
            S_TICK: begin
                o_cmd.tick_wb = 1'b1;
                if (i_sts.wb_last) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            // lowest runnable slot, idle slot as fallback
            S_DISP: begin
                if (i_sts.run_hit || i_sts.idx_last) begin
                    o_cmd.disp_take = 1'b1;
                    n_state         = S_DONE;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_CMPL: begin
                o_cmd.cmpl_wb = 1'b1;
                n_state       = S_DONE;
            end
            S_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

[hdl/cts_dpath.sv]
module cts_dpath #(
    parameter int TASK_SLOTS  = 8,
    parameter int PERIOD_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cts_pkg::t_in_item  i_in_item,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata,
    input  cts_pkg::t_cmd      i_cmd,
    output cts_pkg::t_sts      o_sts,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output cts_pkg::t_out_item o_out_item
);

    localparam int              SW   = $clog2(TASK_SLOTS);
    localparam logic [SW-1:0]   LAST = SW'(TASK_SLOTS - 1);
    localparam int              VIS  = (TASK_SLOTS < cts_pkg::MASK_BITS) ?
                                       TASK_SLOTS : cts_pkg::MASK_BITS;

    // Slot tables
    logic [1:0]             st_mem  [TASK_SLOTS];
    logic [PERIOD_BITS-1:0] cnt_mem [TASK_SLOTS];
    logic [PERIOD_BITS-1:0] per_mem [TASK_SLOTS];

    logic [TASK_SLOTS-1:0]  r_st_vld;
    logic [TASK_SLOTS-1:0]  r_per_vld;
    logic [TASK_SLOTS-1:0]  r_run;

    logic                   r_enable;
    cts_pkg::t_in_item      r_item;
    logic [SW-1:0]          r_idx;
    logic [SW-1:0]          r_cur;
    logic                   r_fell;

    // Registered read data
    logic [SW-1:0]          r_addr_q;
    logic [1:0]             r_st_q;
    logic                   r_st_v;
    logic [PERIOD_BITS-1:0] r_cnt_q;
    logic [PERIOD_BITS-1:0] r_per_q;
    logic                   r_per_v;

    cts_pkg::t_out_item     r_out;
    logic                   r_out_vld;

    logic [SW-1:0]          rd_addr;
    logic [1:0]             st_eff;
    logic [PERIOD_BITS-1:0] per_eff;
    logic                   rdy;
    logic                   req_ok;
    logic [SW-1:0]          req_idx;

    logic                   st_we;
    logic [SW-1:0]          st_waddr;
    logic [1:0]             st_wdata;
    logic                   cnt_we;
    logic [PERIOD_BITS-1:0] cnt_wdata;
    logic                   per_we;

    logic [cts_pkg::MASK_BITS-1:0] run_vis;

    assign rd_addr = i_cmd.rd_cur ? r_cur : r_idx;
    assign req_idx = SW'(r_item.task_req);
    assign req_ok  = (32'(r_item.task_req) < TASK_SLOTS);

    // Never-written entries read as their reset values
    assign st_eff  = r_st_v ? r_st_q :
                     ((r_addr_q == LAST) ? cts_pkg::ST_RUNNABLE : cts_pkg::ST_BLOCKED);
    assign per_eff = r_per_v ? r_per_q : '0;

    // Slots past the mask width always count as ready
    assign rdy = (32'(r_addr_q) >= cts_pkg::MASK_BITS) ? 1'b1 : r_item.ready_mask[3'(r_addr_q)];

    // Table write selection
    always_comb begin
        st_we     = 1'b0;
        st_waddr  = r_addr_q;
        st_wdata  = cts_pkg::ST_BLOCKED;
        cnt_we    = 1'b0;
        cnt_wdata = r_cnt_q - 1'b1;
        per_we    = 1'b0;
        if (i_cmd.tick_wb) begin
            case (st_eff)
                cts_pkg::ST_SLEEP: begin
                    if (r_cnt_q != '0) begin
                        cnt_we = 1'b1;
                    end else begin
                        st_we    = 1'b1;
                        st_wdata = rdy ? cts_pkg::ST_RUNNABLE : cts_pkg::ST_BLOCKED;
                    end
                end
                cts_pkg::ST_BLOCKED: begin
                    if (rdy) begin
                        st_we    = 1'b1;
                        st_wdata = cts_pkg::ST_RUNNABLE;
                    end
                end
                cts_pkg::ST_RUNNABLE: begin
                    if (!rdy) begin
                        st_we    = 1'b1;
                        st_wdata = cts_pkg::ST_BLOCKED;
                    end
                end
                default: begin
                end
            endcase
        end else if (i_cmd.disp_take) begin
            st_we    = 1'b1;
            st_waddr = r_idx;
            st_wdata = cts_pkg::ST_RUNNING;
        end else if (i_cmd.cmpl_wb) begin
            if (st_eff == cts_pkg::ST_RUNNING) begin
                st_we = 1'b1;
                if (r_addr_q == LAST) begin
                    st_wdata = cts_pkg::ST_RUNNABLE;
                end else begin
                    st_wdata  = cts_pkg::ST_SLEEP;
                    cnt_we    = 1'b1;
                    cnt_wdata = per_eff;
                end
            end
        end else if (i_cmd.req_wr && req_ok) begin
            if (r_item.kind == cts_pkg::KIND_MAKE_READY) begin
                st_we    = 1'b1;
                st_waddr = req_idx;
                st_wdata = cts_pkg::ST_RUNNABLE;
            end
            if (r_item.kind == cts_pkg::KIND_SET_PERIOD) begin
                per_we = 1'b1;
            end
        end
    end

    // Table memories
    always_ff @(posedge i_clk) begin
        if (st_we) begin
            st_mem[st_waddr] <= st_wdata;
        end
        if (cnt_we) begin
            cnt_mem[r_addr_q] <= cnt_wdata;
        end
        if (per_we) begin
            per_mem[req_idx] <= PERIOD_BITS'(r_item.period_value);
        end
        r_st_q  <= st_mem[rd_addr];
        r_cnt_q <= cnt_mem[rd_addr];
        r_per_q <= per_mem[rd_addr];
    end

    // Valid bits, runnable shadow and read tags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st_vld  <= '0;
            r_per_vld <= '0;
            r_run     <= TASK_SLOTS'(1) << (TASK_SLOTS - 1);
            r_st_v    <= 1'b0;
            r_per_v   <= 1'b0;
            r_addr_q  <= '0;
        end else begin
            if (st_we) begin
                r_st_vld[st_waddr] <= 1'b1;
                r_run[st_waddr]    <= (st_wdata == cts_pkg::ST_RUNNABLE);
            end
            if (per_we) begin
                r_per_vld[req_idx] <= 1'b1;
            end
            r_st_v   <= r_st_vld[rd_addr];
            r_per_v  <= r_per_vld[rd_addr];
            r_addr_q <= rd_addr;
        end
    end

    // Item capture, walk index, current slot, enable
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_idx    <= '0;
            r_cur    <= '0;
            r_fell   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_enable <= i_cfg_wdata;
            end
            if (i_cmd.load_item) begin
                r_idx  <= '0;
                r_fell <= 1'b0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.disp_take) begin
                r_cur  <= r_idx;
                r_fell <= !r_run[r_idx];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_item <= i_in_item;
        end
    end

    // Visible part of the runnable set
    always_comb begin
        run_vis = '0;
        for (int i = 0; i < VIS; i++) begin
            run_vis[i] = r_run[i];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.chosen_task  <= 3'(r_cur);
            r_out.fell_back    <= r_fell;
            r_out.runnable_set <= run_vis;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

    // Status to controller
    assign o_sts.kind     = r_item.kind;
    assign o_sts.enable   = r_enable;
    assign o_sts.run_hit  = r_run[r_idx];
    assign o_sts.idx_last = (r_idx == LAST);
    assign o_sts.wb_last  = (r_addr_q == LAST);
    assign o_sts.out_busy = r_out_vld && !i_out_ready;

endmodule

[hdl/cooperative_task_scheduler.sv]
// Fixed-priority cooperative task scheduler.
// Input channel (i_in_valid / o_in_ready / i_in_item) takes one command item:
// tick, dispatch, complete, make_ready or set_period. Output channel
// (o_out_valid / i_out_ready / o_out_item) returns one result item per input
// item: current slot, idle-fallback flag and the runnable set after the item.
// Config port: i_cfg_we / i_cfg_wdata write the enable bit at any idle time.
// One item is worked at a time:
//   tick (enabled): walks every slot in turn, one slot per cycle
//   through the status and countdown memories;
//   dispatch: tests slots from the lowest up, one slot tested per cycle;
//   complete: reads the current slot, then writes it back; other kinds: no slot walk.
// The result sits in an output register; a stalled receiver holds the
// block in its final step until the register frees, then input is taken again.
// Reset: every slot blocked except the idle (last) slot, which is runnable;
// periods zero, current slot zero, enable low. No clearing
// pass is needed; the block takes items right after reset.
module cooperative_task_scheduler #(
    parameter int TASK_SLOTS  = 8,
    parameter int PERIOD_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  cts_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output cts_pkg::t_out_item o_out_item,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata
);

    cts_pkg::t_cmd cmd;
    cts_pkg::t_sts sts;

    // Sequencer
    cts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Slot tables and result register
    cts_dpath #(
        .TASK_SLOTS  (TASK_SLOTS),
        .PERIOD_BITS (PERIOD_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule
